// File: design/msta_pkg.sv
// Shared constants, types and helpers for the multi-stream timestamp aligner.
// No dependencies; all other files but msta_ram use it by scoped names.
`default_nettype none

package msta_pkg;

	// Built stream count and per-stream queue depth (depth is a power of two)
	localparam int MAX_STREAMS = 4;
	localparam int QUEUE_DEPTH = 16;

	// Field widths
	localparam int STREAM_W   = 2;
	localparam int TIME_W     = 48;
	localparam int WINDOW_W   = 32;
	localparam int FRAME_W    = 32;
	localparam int SIU_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Derived widths
	localparam int N_W       = $clog2(MAX_STREAMS + 1);
	localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = STREAM_W + SLOT_W;
	localparam int RAM_DEPTH = MAX_STREAMS * QUEUE_DEPTH;

	// Command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Reset values of the configuration registers
	localparam logic [WINDOW_W-1:0] MATCH_WINDOW_RST   = WINDOW_W'(33333);
	localparam logic [SIU_W-1:0]    STREAMS_IN_USE_RST = SIU_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_WINDOW   = 1'b0,
		REG_STREAMS_IN_USE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_MATCH     = 1'b0,
		KIND_FULL_DROP = 1'b1
	} result_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_FULL
	} back_state_t;

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [TIME_W-1:0]   frame_time;
	} cmd_t;

	// Clamp the programmed stream count to 1 .. MAX_STREAMS
	function automatic logic [N_W-1:0] eff_streams(input logic [SIU_W-1:0] v);
		logic [N_W-1:0] n;
		if (v == '0) begin
			n = N_W'(1);
		end else if (int'(v) > MAX_STREAMS) begin
			n = N_W'(MAX_STREAMS);
		end else begin
			n = N_W'(v);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: design/msta_if.sv
// Channel interfaces of the aligner: frame input, result output, config writes.
// Depends on msta_pkg for widths and types.
`default_nettype none

interface msta_frame_if;
	logic                          valid;
	logic                          ready;
	logic [msta_pkg::STREAM_W-1:0] source_stream;
	logic [msta_pkg::TIME_W-1:0]   frame_time;

	modport source(output valid, source_stream, frame_time, input ready);
	modport sink(input valid, source_stream, frame_time, output ready);
endinterface

interface msta_result_if;
	logic                          valid;
	logic                          ready;
	msta_pkg::result_kind_t        result_kind;
	logic [msta_pkg::STREAM_W-1:0] result_stream;
	logic [msta_pkg::FRAME_W-1:0]  frame_number;
	logic                          last_of_run;

	modport source(output valid, result_kind, result_stream, frame_number, last_of_run,
		input ready);
	modport sink(input valid, result_kind, result_stream, frame_number, last_of_run,
		output ready);
endinterface

interface msta_cfg_if;
	logic                            valid;
	logic                            ready;
	msta_pkg::cfg_reg_t              index;
	logic [msta_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/msta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module msta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/msta_front.sv
// Front end: accepts frame items, drops those of streams not in use, and
// queues the rest for the back end. Depends on msta_pkg and msta_if.
`default_nettype none

module msta_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [msta_pkg::N_W-1:0]   n_active,
	msta_frame_if.sink                      frames,
	output logic                            cmd_valid,
	input  wire logic                       cmd_ready,
	output msta_pkg::cmd_t                  cmd
);

	msta_pkg::cmd_t                     cmd_q [msta_pkg::CMD_DEPTH];
	logic [msta_pkg::CMD_PTR_W-1:0]     wr_ptr_q;
	logic [msta_pkg::CMD_PTR_W-1:0]     rd_ptr_q;
	logic [msta_pkg::CMD_CNT_W-1:0]     count_q;
	logic                               in_use;
	logic                               push;
	logic                               pop;

	assign frames.ready = (count_q != msta_pkg::CMD_CNT_W'(msta_pkg::CMD_DEPTH));
	assign in_use       = (msta_pkg::N_W'(frames.source_stream) < n_active);
	assign push         = frames.valid && frames.ready && in_use;
	assign cmd_valid    = (count_q != '0);
	assign pop          = cmd_valid && cmd_ready;
	assign cmd          = cmd_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + msta_pkg::CMD_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + msta_pkg::CMD_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + msta_pkg::CMD_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - msta_pkg::CMD_CNT_W'(1);
			end
		end
	end

	// Queue payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q].stream     <= frames.source_stream;
			cmd_q[wr_ptr_q].frame_time <= frames.frame_time;
		end
	end

endmodule

`default_nettype wire

// File: design/msta_back.sv
// Back end: per-stream timestamp queues in RAM, head scan, match or drop,
// and the result output register. Depends on msta_pkg, msta_if, msta_ram.
`default_nettype none

module msta_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [msta_pkg::N_W-1:0]      n_active,
	input  wire logic [msta_pkg::WINDOW_W-1:0] match_window,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire msta_pkg::cmd_t                cmd,
	msta_result_if.source                      results
);

	msta_pkg::back_state_t state_q, state_d;

	logic [msta_pkg::FILL_W-1:0]   fill_q  [msta_pkg::MAX_STREAMS];
	logic [msta_pkg::SLOT_W-1:0]   slot_q  [msta_pkg::MAX_STREAMS];
	logic [msta_pkg::FRAME_W-1:0]  count_q [msta_pkg::MAX_STREAMS];
	logic [msta_pkg::STREAM_W-1:0] cur_stream_q;
	logic [msta_pkg::STREAM_W-1:0] scan_idx_q;
	logic [msta_pkg::STREAM_W-1:0] lo_idx_q;
	logic [msta_pkg::STREAM_W-1:0] emit_idx_q;
	logic [msta_pkg::TIME_W-1:0]   lo_q;
	logic [msta_pkg::TIME_W-1:0]   hi_q;

	logic                          out_valid_q;
	msta_pkg::result_kind_t        out_kind_q;
	logic [msta_pkg::STREAM_W-1:0] out_stream_q;
	logic [msta_pkg::FRAME_W-1:0]  out_frame_q;
	logic                          out_last_q;

	logic                            out_free;
	logic                            cmd_full;
	logic                            heads_ready;
	logic                            scan_last;
	logic                            is_match;
	logic                            emit_last;
	logic [msta_pkg::TIME_W-1:0]     spread;
	logic [msta_pkg::TIME_W-1:0]     head_time;
	logic [msta_pkg::STREAM_W-1:0]   rd_idx;
	logic [msta_pkg::SLOT_W-1:0]     wr_slot;
	logic [msta_pkg::ADDR_W-1:0]     waddr;
	logic [msta_pkg::ADDR_W-1:0]     raddr;
	logic                            ram_we;
	logic                            load_out;
	logic [msta_pkg::MAX_STREAMS-1:0] push_vec;
	logic [msta_pkg::MAX_STREAMS-1:0] pop_vec;

	msta_ram #(
		.WIDTH(msta_pkg::TIME_W),
		.DEPTH(msta_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (cmd.frame_time),
		.raddr (raddr),
		.rdata (head_time)
	);

	// Status
	always_comb begin
		out_free  = !out_valid_q || results.ready;
		cmd_full  = (fill_q[cmd.stream] == msta_pkg::FILL_W'(msta_pkg::QUEUE_DEPTH));
		heads_ready = 1'b1;
		for (int i = 0; i < msta_pkg::MAX_STREAMS; i++) begin
			if ((msta_pkg::N_W'(i) < n_active) && (fill_q[i] == '0)) begin
				heads_ready = 1'b0;
			end
		end
		scan_last = ((msta_pkg::N_W'(scan_idx_q) + msta_pkg::N_W'(1)) >= n_active);
		spread    = hi_q - lo_q;
		is_match  = (spread <= msta_pkg::TIME_W'(match_window));
		emit_last = ((msta_pkg::N_W'(emit_idx_q) + msta_pkg::N_W'(1)) == n_active);
		wr_slot   = msta_pkg::SLOT_W'(msta_pkg::FILL_W'(slot_q[cmd.stream])
			+ fill_q[cmd.stream]);
		waddr     = {cmd.stream, wr_slot};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msta_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = cmd_full ? msta_pkg::ST_FULL : msta_pkg::ST_CHECK;
				end
			end
			msta_pkg::ST_CHECK: begin
				state_d = heads_ready ? msta_pkg::ST_SCAN : msta_pkg::ST_IDLE;
			end
			msta_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = msta_pkg::ST_DECIDE;
				end
			end
			msta_pkg::ST_DECIDE: begin
				state_d = is_match ? msta_pkg::ST_EMIT : msta_pkg::ST_CHECK;
			end
			msta_pkg::ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = msta_pkg::ST_IDLE;
				end
			end
			msta_pkg::ST_FULL: begin
				if (out_free) begin
					state_d = msta_pkg::ST_IDLE;
				end
			end
			default: state_d = msta_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		load_out  = 1'b0;
		push_vec  = '0;
		pop_vec   = '0;
		rd_idx    = scan_idx_q + msta_pkg::STREAM_W'(1);
		case (state_q)
			msta_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && !cmd_full) begin
					ram_we             = 1'b1;
					push_vec[cmd.stream] = 1'b1;
				end
			end
			msta_pkg::ST_CHECK: begin
				rd_idx = '0;
			end
			msta_pkg::ST_SCAN: begin
			end
			msta_pkg::ST_DECIDE: begin
				if (!is_match) begin
					pop_vec[lo_idx_q] = 1'b1;
				end
			end
			msta_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out            = 1'b1;
					pop_vec[emit_idx_q] = 1'b1;
				end
			end
			msta_pkg::ST_FULL: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
		raddr = {rd_idx, slot_q[rd_idx]};
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msta_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < msta_pkg::MAX_STREAMS; i++) begin
				fill_q[i]  <= '0;
				slot_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			for (int i = 0; i < msta_pkg::MAX_STREAMS; i++) begin
				if (push_vec[i]) begin
					fill_q[i] <= fill_q[i] + msta_pkg::FILL_W'(1);
				end else if (pop_vec[i]) begin
					fill_q[i]  <= fill_q[i] - msta_pkg::FILL_W'(1);
					slot_q[i]  <= slot_q[i] + msta_pkg::SLOT_W'(1);
					count_q[i] <= count_q[i] + msta_pkg::FRAME_W'(1);
				end
			end
		end
	end

	// Scan and result payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == msta_pkg::ST_IDLE && cmd_valid) begin
			cur_stream_q <= cmd.stream;
		end
		if (state_q == msta_pkg::ST_CHECK) begin
			scan_idx_q <= '0;
		end
		if (state_q == msta_pkg::ST_SCAN) begin
			scan_idx_q <= scan_idx_q + msta_pkg::STREAM_W'(1);
			if (scan_idx_q == '0 || head_time < lo_q) begin
				lo_q     <= head_time;
				lo_idx_q <= scan_idx_q;
			end
			if (scan_idx_q == '0 || head_time > hi_q) begin
				hi_q <= head_time;
			end
		end
		if (state_q == msta_pkg::ST_DECIDE) begin
			emit_idx_q <= '0;
		end
		if (state_q == msta_pkg::ST_EMIT && out_free) begin
			emit_idx_q <= emit_idx_q + msta_pkg::STREAM_W'(1);
		end
		if (load_out) begin
			if (state_q == msta_pkg::ST_FULL) begin
				out_kind_q   <= msta_pkg::KIND_FULL_DROP;
				out_stream_q <= cur_stream_q;
				out_frame_q  <= '0;
				out_last_q   <= 1'b1;
			end else begin
				out_kind_q   <= msta_pkg::KIND_MATCH;
				out_stream_q <= emit_idx_q;
				out_frame_q  <= count_q[emit_idx_q];
				out_last_q   <= emit_last;
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.result_kind   = out_kind_q;
	assign results.result_stream = out_stream_q;
	assign results.frame_number  = out_frame_q;
	assign results.last_of_run   = out_last_q;

	// A queue never pops empty and never exceeds its depth
	for (genvar g = 0; g < msta_pkg::MAX_STREAMS; g++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			pop_vec[g] |-> (fill_q[g] != '0))
			else $error("pop from empty stream queue");
		assert property (@(posedge clk) disable iff (!arst_n)
			fill_q[g] <= msta_pkg::FILL_W'(msta_pkg::QUEUE_DEPTH))
			else $error("stream queue fill above depth");
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msta_pkg::ST_DECIDE) |-> (hi_q >= lo_q))
		else $error("head scan left max below min");

	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.last_of_run && results.result_kind == msta_pkg::KIND_MATCH)
		|-> ((msta_pkg::N_W'(results.result_stream) + msta_pkg::N_W'(1)) == n_active))
		else $error("match run closed on a stream other than the highest in use");

endmodule

`default_nettype wire

// File: design/multi_stream_timestamp_aligner.sv
// Top level of the multi-stream timestamp aligner: config registers and the
// front/back split. Depends on msta_pkg, msta_if, msta_front, msta_back.
//
//  channel   dir  handshake      payload
//  frames    in   valid/ready    source_stream[1:0], frame_time[47:0]
//  results   out  valid/ready    result_kind, result_stream[1:0], frame_number[31:0],
//                                last_of_run
//  cfg       in   valid/ready    index (0 match_window, 1 streams_in_use), data[31:0]
//
// The front takes a frame every cycle while its two-entry command queue has room.
// The back handles one queued frame at a time: a push or a full-queue drop, then,
// if all active queues hold a head, a head comparison pass (check, one RAM head
// read per active stream, decide), repeated once per dropped head, then one match
// result per active stream. The single read port of the timestamp RAM sets the
// scan length. Reset clears the queues and counters and resets both registers.
// A stalled result output holds the back sequencer; the front keeps queueing.
`default_nettype none

module multi_stream_timestamp_aligner (
	input  wire logic     clk,
	input  wire logic     arst_n,
	msta_frame_if.sink    frames,
	msta_result_if.source results,
	msta_cfg_if.sink      cfg
);

	logic [msta_pkg::WINDOW_W-1:0] match_window_q;
	logic [msta_pkg::SIU_W-1:0]    streams_in_use_q;
	logic [msta_pkg::N_W-1:0]      n_active;

	logic           cmd_valid;
	logic           cmd_ready;
	msta_pkg::cmd_t cmd;

	// Take all config writes; user must write only while the block is idle (unchecked)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_window_q   <= msta_pkg::MATCH_WINDOW_RST;
			streams_in_use_q <= msta_pkg::STREAMS_IN_USE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				msta_pkg::REG_MATCH_WINDOW:   match_window_q   <= cfg.data;
				msta_pkg::REG_STREAMS_IN_USE: streams_in_use_q <= cfg.data[msta_pkg::SIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the programmed count: zero acts as one, above the built count saturates
	assign n_active = msta_pkg::eff_streams(streams_in_use_q);

	// Front: accept, drop unused streams, queue
	msta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_active  (n_active),
		.frames    (frames),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back: push, scan heads, match or drop, emit
	msta_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_active     (n_active),
		.match_window (match_window_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.results      (results)
	);

endmodule

`default_nettype wire
